// ----- src/lob_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and codes of the limit order book matcher.
// ----------------------------------------------------------------------------
package lob_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] stock_id;
        logic [19:0] limit_price;
        logic [15:0] quantity;
        logic        side;
        logic [15:0] target_id;
    } in_t;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [15:0] out_order_id;
        logic [15:0] out_other_id;
        logic [13:0] out_stock;
        logic [20:0] out_price;
        logic [15:0] out_quantity;
        logic        out_side;
        logic        out_last;
    } out_t;

    typedef struct packed {
        logic [13:0] stock;
        logic [15:0] id;
        logic [19:0] price;
        logic [15:0] qty;
    } entry_t;

    localparam logic [1:0] CMD_NOP    = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SETQTY = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        entry_t     ent;
    } book_op_t;

    localparam logic [1:0] MODE_SUBMIT = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] KIND_ACK       = 3'd0;
    localparam logic [2:0] KIND_DEAL      = 3'd1;
    localparam logic [2:0] KIND_LISTED    = 3'd2;
    localparam logic [2:0] KIND_CANCELLED = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_FULL      = 3'd5;
    localparam logic [2:0] KIND_QRY_DONE  = 3'd6;

endpackage
`default_nettype wire

// ----- src/lob_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lob_cell
// One book slot: holds an order and takes a neighbor's order on shifts.
// ----------------------------------------------------------------------------
module lob_cell (
    input  wire logic            clk,
    input  wire logic [1:0]      cmd,
    input  wire logic            here,
    input  wire logic            after,
    input  wire lob_pkg::entry_t left,
    input  wire lob_pkg::entry_t right,
    input  wire lob_pkg::entry_t fresh,
    output lob_pkg::entry_t      ent
);
    import lob_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (here)
                begin
                    ent_next = fresh;
                end
                else if (after)
                begin
                    ent_next = left;
                end
            end
            CMD_REMOVE:
            begin
                if (here || after)
                begin
                    ent_next = right;
                end
            end
            CMD_SETQTY:
            begin
                if (here)
                begin
                    ent_next.qty = fresh.qty;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule
`default_nettype wire

// ----- src/lob_book.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lob_book
// Compacted sorted book built as a row of shifting cells with a fill count.
// ----------------------------------------------------------------------------
module lob_book #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire lob_pkg::book_op_t          op,
    input  wire logic [$clog2(DEPTH)-1:0]   idx,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_idx,
    output lob_pkg::entry_t                 rd,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    import lob_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          ents [DEPTH];
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        lob_cell u_cell (
            .clk   (clk),
            .cmd   (op.cmd),
            .here  (idx == AW'(i)),
            .after (AW'(i) > idx),
            .left  (ents[(i == 0) ? 0 : i - 1]),
            .right (ents[(i == DEPTH - 1) ? i : i + 1]),
            .fresh (op.ent),
            .ent   (ents[i])
        );
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (op.cmd == CMD_INSERT)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (op.cmd == CMD_REMOVE)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign rd    = ents[rd_idx];
    assign count = cnt_reg;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("book count out of range");
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (op.cmd == CMD_INSERT) |-> (cnt_reg < CW'(DEPTH)))
        else $error("insert into full book");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (op.cmd == CMD_REMOVE) |-> (cnt_reg != '0) && (CW'(idx) < cnt_reg))
        else $error("remove outside filled range");
`endif

endmodule
`default_nettype wire

// ----- src/limit_order_book_matcher_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_book_matcher_unit
// Price-time priority matcher over a buy book and a sell book.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the command transfers on a
//   clock edge with start high and busy low. busy falls in the cycle that
//   presents the last result of the command.
//   Result channel: every result is on result for one cycle with strobe
//   high; out_last marks the final result of a command. The receiver cannot
//   stall, so results must be taken as they come.
// Sequence:
//   Submit: a scan of the own book finds the place of the order, which is
//   then inserted; each opposite book scan for the best match then leads to
//   a fill, until the order is filled or a scan finds no match, and a closing
//   state ends it. Zero quantity and a full book skip placing and matching.
//   Query and cancel scan the buy book, then the sell book; cancel stops at a
//   match. A new command transfers on the first edge with busy low. Unused
//   mode three transfers, never raises busy and gives no result.
// Reset:
//   Both books empty, next order id one, no result pending.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_unit #(
    parameter int BOOK_DEPTH = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lob_pkg::in_t  item,
    output logic               strobe,
    output lob_pkg::out_t      result
);
    import lob_pkg::*;

    localparam int AW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FULL  = 4'd1;
    localparam logic [3:0] S_POS   = 4'd2;
    localparam logic [3:0] S_INS   = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_QRY_B = 4'd6;
    localparam logic [3:0] S_QRY_S = 4'd7;
    localparam logic [3:0] S_CAN_B = 4'd8;
    localparam logic [3:0] S_CAN_S = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [15:0]   nid_reg, nid_next;
    logic          pend_v_reg, pend_v_next;
    logic          strobe_reg, strobe_next;
    out_t          pend_reg, pend_next;
    out_t          out_reg, out_next;
    in_t           cur_reg, cur_next;
    logic [15:0]   id_reg, id_next;
    logic [15:0]   rem_reg, rem_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] best_reg, best_next;
    logic [19:0]   bp_reg, bp_next;
    logic          found_reg, found_next;

    book_op_t      buy_op, sell_op;
    logic [AW-1:0] buy_idx, sell_idx, rd_idx;
    entry_t        buy_rd, sell_rd, own_rd, opp_rd;
    logic [CW-1:0] buy_cnt, sell_cnt, own_cnt, opp_cnt;
    book_op_t      own_op, opp_op;
    logic [AW-1:0] own_idx, opp_idx;

    logic          do_push;
    out_t          push_val;
    logic          start_ok;
    logic [15:0]   rq, dq;

    lob_book #(.DEPTH(BOOK_DEPTH)) u_buy (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (buy_op),
        .idx    (buy_idx),
        .rd_idx (rd_idx),
        .rd     (buy_rd),
        .count  (buy_cnt)
    );

    lob_book #(.DEPTH(BOOK_DEPTH)) u_sell (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (sell_op),
        .idx    (sell_idx),
        .rd_idx (rd_idx),
        .rd     (sell_rd),
        .count  (sell_cnt)
    );

    assign own_rd  = cur_reg.side ? sell_rd  : buy_rd;
    assign opp_rd  = cur_reg.side ? buy_rd   : sell_rd;
    assign own_cnt = cur_reg.side ? sell_cnt : buy_cnt;
    assign opp_cnt = cur_reg.side ? buy_cnt  : sell_cnt;
    assign rd_idx  = (state_reg == S_FILL) ? best_reg : j_reg[AW-1:0];
    assign rq      = opp_rd.qty;
    assign dq      = (rq < rem_reg) ? rq : rem_reg;
    assign start_ok = start && (state_reg == S_IDLE);

    always_comb
    begin
        buy_op   = '0;
        sell_op  = '0;
        buy_idx  = own_idx;
        sell_idx = opp_idx;
        if (cur_reg.side)
        begin
            sell_op  = own_op;
            sell_idx = own_idx;
            buy_op   = opp_op;
            buy_idx  = opp_idx;
        end
        else
        begin
            buy_op   = own_op;
            sell_op  = opp_op;
        end
        if (state_reg == S_CAN_B)
        begin
            buy_op.cmd = ((j_reg != buy_cnt) && (buy_rd.id == cur_reg.target_id))
                         ? CMD_REMOVE : CMD_NOP;
            buy_idx    = j_reg[AW-1:0];
            sell_op    = '0;
        end
        else if (state_reg == S_CAN_S)
        begin
            sell_op.cmd = ((j_reg != sell_cnt) && (sell_rd.id == cur_reg.target_id))
                          ? CMD_REMOVE : CMD_NOP;
            sell_idx    = j_reg[AW-1:0];
            buy_op      = '0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        nid_next    = nid_reg;
        cur_next    = cur_reg;
        id_next     = id_reg;
        rem_next    = rem_reg;
        j_next      = j_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        bp_next     = bp_reg;
        found_next  = found_reg;
        do_push     = 1'b0;
        push_val    = '0;
        own_op      = '0;
        opp_op      = '0;
        own_idx     = pos_reg[AW-1:0];
        opp_idx     = best_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        strobe_next = 1'b0;
        out_next    = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start_ok)
                begin
                    cur_next = item;
                    id_next  = nid_reg;
                    rem_next = item.quantity;
                    j_next   = '0;
                    unique case (item.mode)
                        MODE_SUBMIT:
                        begin
                            nid_next = nid_reg + 16'd1;
                            do_push  = 1'b1;
                            push_val = '{KIND_ACK, nid_reg, 16'd0, item.stock_id,
                                         {1'b0, item.limit_price}, item.quantity,
                                         item.side, 1'b0};
                            if (item.quantity == 16'd0)
                            begin
                                state_next = S_DONE;
                            end
                            else if ((item.side ? sell_cnt : buy_cnt) == CW'(BOOK_DEPTH))
                            begin
                                state_next = S_FULL;
                            end
                            else
                            begin
                                state_next = S_POS;
                            end
                        end
                        MODE_QUERY:  state_next = S_QRY_B;
                        MODE_CANCEL: state_next = S_CAN_B;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_FULL:
            begin
                do_push    = 1'b1;
                push_val   = '{KIND_FULL, id_reg, 16'd0, cur_reg.stock_id,
                               {1'b0, cur_reg.limit_price}, cur_reg.quantity,
                               cur_reg.side, 1'b0};
                state_next = S_DONE;
            end
            S_POS:
            begin
                if ((j_reg == own_cnt) ||
                    (cur_reg.side ? (cur_reg.limit_price < own_rd.price)
                                  : (cur_reg.limit_price > own_rd.price)))
                begin
                    pos_next   = j_reg;
                    state_next = S_INS;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_INS:
            begin
                own_op.cmd = CMD_INSERT;
                own_op.ent = '{cur_reg.stock_id, id_reg, cur_reg.limit_price,
                               cur_reg.quantity};
                j_next     = '0;
                found_next = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (j_reg == opp_cnt)
                begin
                    state_next = found_reg ? S_FILL : S_DONE;
                end
                else
                begin
                    if ((opp_rd.stock == cur_reg.stock_id) &&
                        !(cur_reg.side ? (opp_rd.price < cur_reg.limit_price)
                                       : (opp_rd.price > cur_reg.limit_price)) &&
                        (!found_reg || (cur_reg.side ? (opp_rd.price > bp_reg)
                                                     : (opp_rd.price < bp_reg))))
                    begin
                        found_next = 1'b1;
                        best_next  = j_reg[AW-1:0];
                        bp_next    = opp_rd.price;
                    end
                    j_next = j_reg + CW'(1);
                end
            end
            S_FILL:
            begin
                do_push  = 1'b1;
                push_val = '{KIND_DEAL, id_reg, opp_rd.id, cur_reg.stock_id,
                             {1'b0, cur_reg.limit_price} + {1'b0, bp_reg}, dq,
                             cur_reg.side, 1'b0};
                opp_op.cmd     = (rq == dq) ? CMD_REMOVE : CMD_SETQTY;
                opp_op.ent.qty = rq - dq;
                rem_next       = rem_reg - dq;
                own_op.cmd     = (rem_reg == dq) ? CMD_REMOVE : CMD_SETQTY;
                own_op.ent.qty = rem_reg - dq;
                j_next         = '0;
                found_next     = 1'b0;
                state_next     = (rem_reg == dq) ? S_DONE : S_SCAN;
            end
            S_QRY_B:
            begin
                if (j_reg == buy_cnt)
                begin
                    j_next     = '0;
                    state_next = S_QRY_S;
                end
                else
                begin
                    if (buy_rd.stock == cur_reg.stock_id)
                    begin
                        do_push  = 1'b1;
                        push_val = '{KIND_LISTED, buy_rd.id, 16'd0, cur_reg.stock_id,
                                     {1'b0, buy_rd.price}, buy_rd.qty, 1'b0, 1'b0};
                    end
                    j_next = j_reg + CW'(1);
                end
            end
            S_QRY_S:
            begin
                do_push = 1'b1;
                if (j_reg == sell_cnt)
                begin
                    push_val   = '{KIND_QRY_DONE, 16'd0, 16'd0, cur_reg.stock_id,
                                   21'd0, 16'd0, 1'b0, 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    do_push  = (sell_rd.stock == cur_reg.stock_id);
                    push_val = '{KIND_LISTED, sell_rd.id, 16'd0, cur_reg.stock_id,
                                 {1'b0, sell_rd.price}, sell_rd.qty, 1'b1, 1'b0};
                    j_next   = j_reg + CW'(1);
                end
            end
            S_CAN_B:
            begin
                if (j_reg == buy_cnt)
                begin
                    j_next     = '0;
                    state_next = S_CAN_S;
                end
                else if (buy_rd.id == cur_reg.target_id)
                begin
                    do_push    = 1'b1;
                    push_val   = '{KIND_CANCELLED, cur_reg.target_id, 16'd0, buy_rd.stock,
                                   {1'b0, buy_rd.price}, buy_rd.qty, 1'b0, 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            S_CAN_S:
            begin
                do_push = 1'b1;
                if (j_reg == sell_cnt)
                begin
                    push_val   = '{KIND_NOT_FOUND, cur_reg.target_id, 16'd0, 14'd0,
                                   21'd0, 16'd0, 1'b0, 1'b0};
                    state_next = S_DONE;
                end
                else if (sell_rd.id == cur_reg.target_id)
                begin
                    push_val   = '{KIND_CANCELLED, cur_reg.target_id, 16'd0, sell_rd.stock,
                                   {1'b0, sell_rd.price}, sell_rd.qty, 1'b1, 1'b0};
                    state_next = S_DONE;
                end
                else
                begin
                    do_push = 1'b0;
                    j_next  = j_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                out_next          = pend_reg;
                out_next.out_last = 1'b1;
                strobe_next       = 1'b1;
                pend_v_next       = 1'b0;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_push)
        begin
            if (pend_v_reg)
            begin
                out_next    = pend_reg;
                strobe_next = 1'b1;
            end
            pend_next   = push_val;
            pend_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nid_reg    <= 16'd1;
            pend_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nid_reg    <= nid_next;
            pend_v_reg <= pend_v_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        out_reg   <= out_next;
        cur_reg   <= cur_next;
        id_reg    <= id_next;
        rem_reg   <= rem_next;
        j_reg     <= j_next;
        pos_reg   <= pos_next;
        best_reg  <= best_next;
        bp_reg    <= bp_next;
        found_reg <= found_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = out_reg;

`ifndef ASSERT_OFF
    a_done_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> pend_v_reg)
        else $error("finish with no pending result");
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_v_reg)
        else $error("pending result left behind");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> (strobe_reg && out_reg.out_last))
        else $error("final transfer not marked last");
`endif

endmodule
`default_nettype wire
